// ===== hw/rtl/rlm_pkg.sv =====
package rlm_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int HALF_W      = SAMPLE_BITS - 1;
    localparam int SQ_W        = 2 * SAMPLE_BITS - 3;
    localparam int MEAN_W      = SQ_W;
    localparam int RMS_W       = 15;
    localparam int RAD_W       = 2 * RMS_W;
    localparam int ACC_W       = 31;
    localparam int FRAC_W      = 16;
    localparam int DECAY_W     = 17;
    localparam int IN_DATA_W   = 32;
    localparam int OUT_DATA_W  = 64;

    localparam logic [DECAY_W-1:0] DECAY_ONE   = 17'd65536;
    localparam logic [DECAY_W-1:0] DECAY_RESET = 17'd60948;

    typedef struct packed {
        logic busy;
        logic done;
    } rlm_status_t;

endpackage

// ===== hw/rtl/rlm_lane.sv =====
module rlm_lane
    import rlm_pkg::*;
(
    input  logic                          aclk,
    input  logic                          load,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    output logic        [SQ_W-1:0]        square
);

    logic signed [HALF_W-1:0] halved;
    logic        [HALF_W-1:0] mag;
    logic        [2*HALF_W-1:0] prod;
    logic        [SQ_W-1:0]   square_reg;

    // floor(x/2); magnitude of the most negative value wraps to the right unsigned code
    assign halved = HALF_W'(sample >>> 1);
    assign mag    = (halved ^ {HALF_W{halved[HALF_W-1]}}) + HALF_W'(halved[HALF_W-1]);
    assign prod   = mag * mag;

    always_ff @(posedge aclk) begin
        if (load) begin
            square_reg <= prod[SQ_W-1:0];
        end
    end

    assign square = square_reg;

endmodule

// ===== hw/rtl/rlm_div.sv =====
module rlm_div
    import rlm_pkg::*;
#(
    parameter int SUM_W = 38,
    parameter int CNT_W = 10
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [SUM_W-1:0]  dividend,
    input  logic [CNT_W-1:0]  divisor,
    output logic [MEAN_W-1:0] quotient,
    output rlm_status_t       status
);

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [SUM_W-1:0]  dvd_reg, dvd_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  div_reg, div_next;
    logic [CNT_W:0]    trial;
    logic [CNT_W:0]    diff;
    logic              fits;

    assign trial = {rem_reg, dvd_reg[SUM_W-1]};
    assign diff  = trial - {1'b0, div_reg};
    assign fits  = trial >= {1'b0, div_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = STEP_W'(SUM_W);
            dvd_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
        end else if (busy_reg) begin
            dvd_next  = {dvd_reg[SUM_W-2:0], fits};
            rem_next  = fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
            step_next = step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign quotient    = dvd_reg[MEAN_W-1:0];
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

// ===== hw/rtl/rlm_isqrt.sv =====
module rlm_isqrt
    import rlm_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [MEAN_W-1:0] radicand,
    output logic [RMS_W-1:0]  root,
    output rlm_status_t       status
);

    localparam int STEP_W = $clog2(RMS_W + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [RAD_W-1:0]  rad_reg, rad_next;
    logic [RMS_W:0]    rem_reg, rem_next;
    logic [RMS_W-1:0]  root_reg, root_next;
    logic [RMS_W+2:0]  trial;
    logic [RMS_W+2:0]  sub;
    logic [RMS_W+2:0]  diff;
    logic              fits;

    assign trial = {rem_reg, rad_reg[RAD_W-1 -: 2]};
    assign sub   = {1'b0, root_reg, 2'b01};
    assign diff  = trial - sub;
    assign fits  = trial >= sub;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = STEP_W'(RMS_W);
            rad_next  = RAD_W'(radicand);
            rem_next  = '0;
            root_next = '0;
        end else if (busy_reg) begin
            rad_next  = {rad_reg[RAD_W-3:0], 2'b00};
            rem_next  = fits ? diff[RMS_W:0] : trial[RMS_W:0];
            root_next = {root_reg[RMS_W-2:0], fits};
            step_next = step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign root        = root_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

// ===== hw/rtl/rms_level_meter.sv =====
// Buffer RMS level meter. Each s_axis transfer carries one stereo pair; a pair
// without tlast leaves s_axis_tready high, so pairs can follow back to back. A
// pair with tlast closes the buffer and holds s_axis_tready low while the
// flush, divide, root, multiply and update states run, and while the previous
// result still waits on m_axis_tready. The divide state uses the bit-serial
// divider (one quotient bit per cycle over the SUM_W-bit sum), the root state
// the bit-serial square root (one root bit per cycle). One m_axis transfer per
// buffer gives RMS, smoothed level and peak mean square. Once 2*BUFFER_LEN
// samples are summed in one buffer, further pairs are dropped from the sum.
// decay_q16 values above 65536 act as 65536.
module rms_level_meter
    import rlm_pkg::*;
#(
    parameter int BUFFER_LEN = 256
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // left_sample, right_sample
    input  logic                  s_axis_tlast,  // last_in_buffer
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,  // rms_level, smoothed_level,
                                                 // peak_mean_square, zero pad
    input  logic                  cfg_wr_en,
    input  logic [DECAY_W-1:0]    cfg_wr_data    // decay_q16
);

    localparam int CNT_W = $clog2(2 * BUFFER_LEN + 1);
    localparam int SUM_W = SQ_W - 1 + CNT_W;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_FLUSH  = 3'd1;
    localparam logic [2:0] ST_DIVIDE = 3'd2;
    localparam logic [2:0] ST_ROOT   = 3'd3;
    localparam logic [2:0] ST_MULT   = 3'd4;
    localparam logic [2:0] ST_UPDATE = 3'd5;

    logic [2:0]         state_reg, state_next;
    logic [DECAY_W-1:0] decay_reg;
    logic               sq_valid_reg;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [MEAN_W-1:0]  peak_reg;
    logic [ACC_W-1:0]   acc_reg;
    logic [47:0]        prod_a_reg;
    logic [31:0]        prod_b_reg;
    logic [RMS_W-1:0]   rms_out_reg;
    logic [RMS_W-1:0]   smooth_out_reg;
    logic [MEAN_W-1:0]  peak_out_reg;
    logic               m_valid_reg;

    logic               in_xfer;
    logic               out_free;
    logic               room;
    logic [SQ_W-1:0]    sq_left, sq_right;
    logic [MEAN_W-1:0]  mean;
    logic [RMS_W-1:0]   root;
    logic [DECAY_W-1:0] d_eff, w_eff;
    logic [32:0]        acc_sum;
    rlm_status_t        div_status, sqrt_status;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;

    rlm_lane u_lane_left (
        .aclk   (aclk),
        .load   (in_xfer),
        .sample (s_axis_tdata[SAMPLE_BITS-1:0]),
        .square (sq_left)
    );

    rlm_lane u_lane_right (
        .aclk   (aclk),
        .load   (in_xfer),
        .sample (s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .square (sq_right)
    );

    // merge stage
    assign room = count_reg < CNT_W'(2 * BUFFER_LEN);

    always_comb begin
        sum_next   = sum_reg;
        count_next = count_reg;
        if (state_reg == ST_UPDATE && out_free) begin
            sum_next   = '0;
            count_next = '0;
        end else if (sq_valid_reg && room) begin
            sum_next   = sum_reg + SUM_W'(sq_left) + SUM_W'(sq_right);
            count_next = count_reg + CNT_W'(2);
        end
    end

    rlm_div #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (state_reg == ST_FLUSH),
        .dividend (sum_next),
        .divisor  (count_next),
        .quotient (mean),
        .status   (div_status)
    );

    rlm_isqrt u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (state_reg == ST_DIVIDE && div_status.done),
        .radicand (mean),
        .root     (root),
        .status   (sqrt_status)
    );

    assign d_eff   = decay_reg[DECAY_W-1] ? DECAY_ONE : decay_reg;
    assign w_eff   = DECAY_ONE - d_eff;
    assign acc_sum = {1'b0, prod_a_reg[47:FRAC_W]} + {1'b0, prod_b_reg};

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (in_xfer && s_axis_tlast) state_next = ST_FLUSH;
            ST_FLUSH:  state_next = ST_DIVIDE;
            ST_DIVIDE: if (div_status.done) state_next = ST_ROOT;
            ST_ROOT:   if (sqrt_status.done) state_next = ST_MULT;
            ST_MULT:   state_next = ST_UPDATE;
            ST_UPDATE: if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            decay_reg    <= DECAY_RESET;
            sq_valid_reg <= 1'b0;
            sum_reg      <= '0;
            count_reg    <= '0;
            peak_reg     <= '0;
            acc_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            sq_valid_reg <= in_xfer;
            sum_reg      <= sum_next;
            count_reg    <= count_next;
            if (cfg_wr_en) begin
                decay_reg <= cfg_wr_data;
            end
            if (state_reg == ST_DIVIDE && div_status.done && mean > peak_reg) begin
                peak_reg <= mean;
            end
            if (state_reg == ST_UPDATE && out_free) begin
                acc_reg     <= acc_sum[ACC_W-1:0];
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_MULT) begin
            prod_a_reg <= acc_reg * d_eff;
            prod_b_reg <= root * w_eff;
        end
        if (state_reg == ST_UPDATE && out_free) begin
            rms_out_reg    <= root;
            smooth_out_reg <= acc_sum[ACC_W-1:FRAC_W];
            peak_out_reg   <= peak_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {(OUT_DATA_W - 2 * RMS_W - MEAN_W)'(0),
                            peak_out_reg, smooth_out_reg, rms_out_reg};

`ifndef NO_ASSERTIONS
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tready |-> !div_status.busy && !sqrt_status.busy)
        else $error("input taken while divider or root unit busy");

    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_axis_tvalid) |-> count_reg == '0 && sum_reg == '0)
        else $error("accumulator not cleared with result");

    assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> peak_reg >= $past(peak_reg))
        else $error("peak mean square decreased");

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(2 * BUFFER_LEN))
        else $error("sample count beyond buffer length");
`endif

endmodule

// ===== sim/rms_level_meter_tb.sv =====
`timescale 1ns / 100ps

module rms_level_meter_tb;
    import rlm_pkg::*;

    localparam int BUF_LEN       = 256;
    localparam int QUIET_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 100;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASE_ITEMS   = 155;

    typedef struct packed {
        logic [RMS_W-1:0]  rms;
        logic [RMS_W-1:0]  smooth;
        logic [MEAN_W-1:0] peak;
    } levels_t;

    typedef enum {ROW_PAIR, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t          kind;
        logic [DECAY_W-1:0] cfg_val;
        logic [15:0]        left;
        logic [15:0]        right;
        bit                 last;
        int                 reps;
        bit                 typed;
        levels_t            want;
    } row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  s_tlast = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  cfg_wr_en = 1'b0;
    logic [DECAY_W-1:0]    cfg_wr_data = '0;

    // model state
    logic [DECAY_W-1:0] decay_m      = DECAY_RESET;
    logic [37:0]        sq_sum_m     = '0;
    logic [9:0]         smp_cnt_m    = '0;
    logic [ACC_W-1:0]   smooth_acc_m = '0;
    logic [MEAN_W-1:0]  peak_m       = '0;

    levels_t level_q[$];
    int      err_count = 0;
    int      quiet_cycles = 0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;
    int      hold_left = 0;
    bit      hold_req = 1'b0;

    row_t dir_tab [0:22] = '{
        '{ROW_PAIR, 17'd0, 16'h0000, 16'h0000, 1'b1, 1,   1'b1,
          '{15'd0, 15'd0, 29'd0}},
        '{ROW_PAIR, 17'd0, 16'h8000, 16'h8000, 1'b1, 1,   1'b1,
          '{15'd16384, 15'd1147, 29'd268435456}},
        '{ROW_PAIR, 17'd0, 16'h7FFF, 16'hFFFF, 1'b0, 1,   1'b0, '{'0, '0, '0}},
        '{ROW_PAIR, 17'd0, 16'h0001, 16'h8001, 1'b1, 1,   1'b0, '{'0, '0, '0}},
        '{ROW_PAIR, 17'd0, 16'hFFFE, 16'h0002, 1'b0, 3,   1'b0, '{'0, '0, '0}},
        '{ROW_PAIR, 17'd0, 16'h5555, 16'hAAAA, 1'b1, 1,   1'b0, '{'0, '0, '0}},
        '{ROW_PAIR, 17'd0, 16'hAAAA, 16'h5555, 1'b1, 1,   1'b0, '{'0, '0, '0}},
        '{ROW_PAIR, 17'd0, 16'h7FFF, 16'h7FFF, 1'b0, 300, 1'b0, '{'0, '0, '0}},
        '{ROW_PAIR, 17'd0, 16'h8000, 16'h8000, 1'b1, 1,   1'b0, '{'0, '0, '0}},
        '{ROW_PAIR, 17'd0, 16'h0000, 16'hFFFF, 1'b0, 255, 1'b0, '{'0, '0, '0}},
        '{ROW_PAIR, 17'd0, 16'h8000, 16'h8000, 1'b1, 1,   1'b0, '{'0, '0, '0}},
        '{ROW_CFG,  17'd0, 16'h0000, 16'h0000, 1'b0, 0,   1'b0, '{'0, '0, '0}},
        '{ROW_PAIR, 17'd0, 16'h8000, 16'h8000, 1'b1, 1,   1'b1,
          '{15'd16384, 15'd16384, 29'd268435456}},
        '{ROW_CFG,  17'd65536, 16'h0000, 16'h0000, 1'b0, 0, 1'b0, '{'0, '0, '0}},
        '{ROW_PAIR, 17'd0, 16'h0000, 16'h0000, 1'b1, 1,   1'b1,
          '{15'd0, 15'd16384, 29'd268435456}},
        '{ROW_CFG,  17'd131071, 16'h0000, 16'h0000, 1'b0, 0, 1'b0, '{'0, '0, '0}},
        '{ROW_PAIR, 17'd0, 16'h0000, 16'h0000, 1'b1, 1,   1'b1,
          '{15'd0, 15'd16384, 29'd268435456}},
        '{ROW_PAIR, 17'd0, 16'h1234, 16'hEDCB, 1'b1, 1,   1'b0, '{'0, '0, '0}},
        '{ROW_CFG,  17'd1, 16'h0000, 16'h0000, 1'b0, 0,   1'b0, '{'0, '0, '0}},
        '{ROW_PAIR, 17'd0, 16'h4000, 16'hC000, 1'b1, 1,   1'b0, '{'0, '0, '0}},
        '{ROW_CFG,  17'd65535, 16'h0000, 16'h0000, 1'b0, 0, 1'b0, '{'0, '0, '0}},
        '{ROW_PAIR, 17'd0, 16'h8000, 16'h7FFF, 1'b1, 1,   1'b0, '{'0, '0, '0}},
        '{ROW_CFG,  17'd60948, 16'h0000, 16'h0000, 1'b0, 0, 1'b0, '{'0, '0, '0}}
    };

    rms_level_meter u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tlast  (s_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic logic [63:0] halved_square(input logic signed [15:0] x);
        logic signed [15:0] h;
        logic [15:0]        a;
        h = x >>> 1;
        a = (h < 0) ? 16'(-h) : 16'(h);
        return 64'(a) * 64'(a);
    endfunction

    function automatic logic [15:0] floor_sqrt(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] t;
        res = '0;
        for (int b = 15; b >= 0; b--) begin
            t = res | (64'd1 << b);
            if (t * t <= v)
                res = t;
        end
        return res[15:0];
    endfunction

    task automatic predict_levels(input logic [15:0] l, input logic [15:0] r,
                                  input bit last, output bit got, output levels_t lv);
        logic [63:0] mean;
        logic [63:0] d;
        logic [63:0] w;
        logic [63:0] acc;
        logic [15:0] root;
        got = 1'b0;
        lv  = '0;
        if (int'(smp_cnt_m) < 2 * BUF_LEN) begin
            sq_sum_m  = sq_sum_m + 38'(halved_square(l)) + 38'(halved_square(r));
            smp_cnt_m = smp_cnt_m + 10'd2;
        end
        if (!last)
            return;
        mean = 64'(sq_sum_m) / 64'(smp_cnt_m);
        if (mean > 64'(peak_m))
            peak_m = mean[MEAN_W-1:0];
        root = floor_sqrt(mean);
        d = (decay_m > DECAY_ONE) ? 64'(DECAY_ONE) : 64'(decay_m);
        w = 64'(DECAY_ONE) - d;
        acc = (64'(smooth_acc_m) * d + (64'(root) << FRAC_W) * w) >> FRAC_W;
        smooth_acc_m = acc[ACC_W-1:0];
        lv.rms    = root[RMS_W-1:0];
        lv.smooth = smooth_acc_m[FRAC_W +: RMS_W];
        lv.peak   = peak_m;
        sq_sum_m  = '0;
        smp_cnt_m = '0;
        got = 1'b1;
    endtask

    task automatic send_pair(input logic [15:0] l, input logic [15:0] r, input bit last,
                             input bit typed, input levels_t typed_lv);
        bit      got;
        levels_t lv;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {r, l};
        s_tlast  <= last;
        do
            @(posedge aclk);
        while (!s_axis_tready);
        predict_levels(l, r, last, got, lv);
        if (got)
            level_q.push_back(typed ? typed_lv : lv);
    endtask

    task automatic drain_out();
        s_tvalid <= 1'b0;
        while (level_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_decay(input logic [DECAY_W-1:0] val);
        drain_out();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        decay_m = val;
    endtask

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            4:       return 16'h0001;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic run_buffers(input int n_items);
        int sent;
        int len;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 79) == 0)
                len = $urandom_range(250, 300);
            else
                len = $urandom_range(1, 8);
            for (int i = 0; i < len; i++)
                send_pair(pick_sample(), pick_sample(), i == len - 1, 1'b0, '0);
            sent += len;
        end
    endtask

    task automatic check_levels(input levels_t got);
        levels_t want;
        if (level_q.size() == 0) begin
            if (err_count < 10)
                $display("unexpected result: rms %0d smooth %0d peak %0d",
                         got.rms, got.smooth, got.peak);
            err_count++;
        end else begin
            want = level_q.pop_front();
            if (got.rms !== want.rms || got.smooth !== want.smooth
                    || got.peak !== want.peak) begin
                if (err_count < 10)
                    $display("mismatch: rms %0d/%0d smooth %0d/%0d peak %0d/%0d (exp/got)",
                             want.rms, got.rms, want.smooth, got.smooth,
                             want.peak, got.peak);
                err_count++;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_tready)
            check_levels('{m_axis_tdata[RMS_W-1:0],
                           m_axis_tdata[2*RMS_W-1:RMS_W],
                           m_axis_tdata[2*RMS_W+MEAN_W-1:2*RMS_W]});
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_axis_tready) || (m_axis_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("rms_level_meter_tb failed");
            $finish;
        end
    end

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_tab[i]) begin
            if (dir_tab[i].kind == ROW_CFG) begin
                write_decay(dir_tab[i].cfg_val);
            end else begin
                for (int k = 0; k < dir_tab[i].reps; k++)
                    send_pair(dir_tab[i].left, dir_tab[i].right,
                              dir_tab[i].last && (k == dir_tab[i].reps - 1),
                              dir_tab[i].typed, dir_tab[i].want);
            end
        end

        for (int ph = 0; ph < 5; ph++) begin
            if (ph % 2 == 0)
                write_decay(17'($urandom_range(0, 131071)));
            else
                write_decay(17'($urandom_range(58000, 65535)));
            case (ph)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 87; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 87; end
                3:       begin send_idle_pct = 28; recv_stall_pct = 28; end
                default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            endcase
            // last phase: long receiver hold-off while items keep coming
            if (ph == 4)
                hold_req = 1'b1;
            run_buffers(PHASE_ITEMS);
        end

        drain_out();
        if (err_count == 0 && level_q.size() == 0)
            $display("rms_level_meter_tb passed");
        else
            $display("rms_level_meter_tb failed");
        $finish;
    end

endmodule
